### sv/xld_pkg.sv
package xld_pkg;

    localparam int KEY_W        = 32;
    localparam int IDX_PW       = 7;
    localparam int CMD_W        = 4;
    localparam int ST_W         = 2;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_FIND       = 4'd4,
        CMD_INS_AFTER  = 4'd5,
        CMD_INS_BEFORE = 4'd6,
        CMD_REMOVE     = 4'd7,
        CMD_REVERSE    = 4'd8
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FAIL,
        OP_SEEK_INIT,
        OP_TAIL_INIT,
        OP_RD_CUR,
        OP_ADVANCE,
        OP_FOUND,
        OP_SCAN_INIT,
        OP_SCAN_STEP,
        OP_TAKE,
        OP_WR_NEW,
        OP_WR_CUR,
        OP_RD_NB,
        OP_WR_NB,
        OP_COMMIT,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_CMP,
        S_POP_RD,
        S_POP_Q,
        S_AFTER,
        S_SCAN,
        S_WR_NEW,
        S_WR_CUR,
        S_NB,
        S_NB_WR,
        S_UNLINK_P,
        S_UNLINK_PW,
        S_UNLINK_N,
        S_UNLINK_NW,
        S_COMMIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t fail_code;
        logic    nb_second;
    } xld_ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic full;
        logic walk_end;
        logic key_hit;
        logic scan_free;
        logic nb_zero;
        logic out_busy;
    } xld_sts_t;

endpackage

### sv/xld_req_if.sv
interface xld_req_if
    import xld_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] new_key;

    modport source (output valid, cmd, key, new_key, input ready);
    modport sink   (input valid, cmd, key, new_key, output ready);
endinterface

### sv/xld_rsp_if.sv
interface xld_rsp_if
    import xld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [KEY_W-1:0]  key_out;
    logic [IDX_PW-1:0] node_index;
    logic [IDX_PW-1:0] count;
    logic              empty_res;

    modport source (output valid, status, key_out, node_index, count, empty_res,
                    input ready);
    modport sink   (input valid, status, key_out, node_index, count, empty_res,
                    output ready);
endinterface

### sv/xld_ctrl.sv
module xld_ctrl
    import xld_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  xld_sts_t sts,
    output xld_ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        state_next = sts.full ? S_EMIT : S_SCAN;
                    CMD_POP_FRONT, CMD_POP_BACK:
                        state_next = sts.empty ? S_EMIT : S_POP_RD;
                    CMD_FIND, CMD_INS_AFTER, CMD_INS_BEFORE, CMD_REMOVE:
                        state_next = sts.empty ? S_EMIT : S_WALK;
                    default:
                        state_next = S_EMIT;
                endcase
            end
            S_WALK:      state_next = sts.walk_end ? S_EMIT : S_CMP;
            S_CMP:       state_next = sts.key_hit ? S_AFTER : S_WALK;
            S_POP_RD:    state_next = S_POP_Q;
            S_POP_Q:     state_next = S_UNLINK_P;
            S_AFTER:
            begin
                unique case (sts.cmd)
                    CMD_FIND:                      state_next = S_EMIT;
                    CMD_INS_AFTER, CMD_INS_BEFORE: state_next = sts.full ? S_EMIT : S_SCAN;
                    default:                       state_next = S_UNLINK_P;
                endcase
            end
            S_SCAN:      state_next = sts.scan_free ? S_WR_NEW : S_SCAN;
            S_WR_NEW:
            begin
                if (sts.cmd == CMD_INS_AFTER || sts.cmd == CMD_INS_BEFORE)
                begin
                    state_next = S_WR_CUR;
                end
                else
                begin
                    state_next = S_NB;
                end
            end
            S_WR_CUR:    state_next = S_NB;
            S_NB:        state_next = sts.nb_zero ? S_COMMIT : S_NB_WR;
            S_NB_WR:     state_next = S_COMMIT;
            S_UNLINK_P:  state_next = sts.nb_zero ? S_UNLINK_N : S_UNLINK_PW;
            S_UNLINK_PW: state_next = S_UNLINK_N;
            S_UNLINK_N:  state_next = sts.nb_zero ? S_COMMIT : S_UNLINK_NW;
            S_UNLINK_NW: state_next = S_COMMIT;
            S_COMMIT:    state_next = S_EMIT;
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.op        = OP_NONE;
        ctl.fail_code = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op = OP_LOAD;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.cmd)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK:
                    begin
                        ctl.op        = sts.full ? OP_FAIL : OP_SCAN_INIT;
                        ctl.fail_code = ST_FULL;
                    end
                    CMD_POP_BACK:
                    begin
                        ctl.op        = sts.empty ? OP_FAIL : OP_TAIL_INIT;
                        ctl.fail_code = ST_EMPTY;
                    end
                    CMD_POP_FRONT, CMD_FIND, CMD_INS_AFTER, CMD_INS_BEFORE, CMD_REMOVE:
                    begin
                        ctl.op        = sts.empty ? OP_FAIL : OP_SEEK_INIT;
                        ctl.fail_code = ST_EMPTY;
                    end
                    default:
                        ctl.op = OP_COMMIT;
                endcase
            end
            S_WALK:
            begin
                ctl.op        = sts.walk_end ? OP_FAIL : OP_RD_CUR;
                ctl.fail_code = ST_ABSENT;
            end
            S_CMP:       ctl.op = sts.key_hit ? OP_FOUND : OP_ADVANCE;
            S_POP_RD:    ctl.op = OP_RD_CUR;
            S_POP_Q:     ctl.op = OP_FOUND;
            S_AFTER:
            begin
                unique case (sts.cmd)
                    CMD_FIND:
                        ctl.op = OP_COMMIT;
                    CMD_INS_AFTER, CMD_INS_BEFORE:
                    begin
                        ctl.op        = sts.full ? OP_FAIL : OP_SCAN_INIT;
                        ctl.fail_code = ST_FULL;
                    end
                    default:
                        ctl.op = OP_NONE;
                endcase
            end
            S_SCAN:      ctl.op = sts.scan_free ? OP_TAKE : OP_SCAN_STEP;
            S_WR_NEW:    ctl.op = OP_WR_NEW;
            S_WR_CUR:    ctl.op = OP_WR_CUR;
            S_NB:        ctl.op = sts.nb_zero ? OP_NONE : OP_RD_NB;
            S_NB_WR:     ctl.op = OP_WR_NB;
            S_UNLINK_P:  ctl.op = sts.nb_zero ? OP_NONE : OP_RD_NB;
            S_UNLINK_PW: ctl.op = OP_WR_NB;
            S_UNLINK_N:
            begin
                ctl.op        = sts.nb_zero ? OP_NONE : OP_RD_NB;
                ctl.nb_second = 1'b1;
            end
            S_UNLINK_NW:
            begin
                ctl.op        = OP_WR_NB;
                ctl.nb_second = 1'b1;
            end
            S_COMMIT:    ctl.op = OP_COMMIT;
            S_EMIT:      ctl.op = sts.out_busy ? OP_NONE : OP_EMIT;
            default:     ctl.op = OP_NONE;
        endcase
    end

endmodule

### sv/xld_dp.sv
module xld_dp
    import xld_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  xld_ctl_t          ctl,
    output xld_sts_t          sts,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [KEY_W-1:0]  in_new_key,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ST_W-1:0]   out_status,
    output logic [KEY_W-1:0]  out_key,
    output logic [IDX_PW-1:0] out_index,
    output logic [IDX_PW-1:0] out_count,
    output logic              out_empty
);

    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

    logic [KW-1:0]    key_mem  [CAPACITY];
    logic [IDX_W-1:0] link_mem [CAPACITY];

    cmd_t             cmd_reg;
    logic [KW-1:0]    key_reg;
    logic [KW-1:0]    nkey_reg;
    logic [KW-1:0]    kq_reg;
    logic [KW-1:0]    khit_reg;
    logic [KW-1:0]    kout_reg;
    logic [IDX_W-1:0] lq_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] prev_reg;
    logic [IDX_W-1:0] nxt_reg;
    logic [IDX_W-1:0] m_reg;
    logic [IDX_W-1:0] scan_reg;
    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] nb_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             nbsec_reg;
    status_t          status_reg;
    logic [CAPACITY-1:0] free_reg;

    logic [ST_W-1:0]   ostat_reg;
    logic [KEY_W-1:0]  okey_reg;
    logic [IDX_PW-1:0] oidx_reg;
    logic [IDX_PW-1:0] ocnt_reg;
    logic              oempty_reg;

    logic [IDX_W-1:0] nb_sel;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] rd_m1;
    logic [IDX_W-1:0] lw_idx;
    logic [IDX_W-1:0] lw_m1;
    logic [IDX_W-1:0] lw_data;
    logic [IDX_W-1:0] m_m1;
    logic [IDX_W-1:0] scan_m1;
    logic [IDX_W-1:0] cur_m1;
    logic [IDX_W-1:0] xval;
    logic [IDX_W-1:0] new_link;
    logic [IDX_W-1:0] cur_link;
    logic [KW-1:0]    new_key_val;
    logic             rd_en;
    logic             lw_en;
    logic             kw_en;
    logic             scan_free;
    logic [KW+KEY_W-1:0]     kout_wide;
    logic [IDX_W+IDX_PW-1:0] idx_wide;
    logic [IDX_W+IDX_PW-1:0] cnt_wide;

    always_comb
    begin
        case (cmd_reg)
            CMD_PUSH_FRONT: nb_sel = head_reg;
            CMD_PUSH_BACK:  nb_sel = tail_reg;
            CMD_INS_AFTER:  nb_sel = nxt_reg;
            CMD_INS_BEFORE: nb_sel = prev_reg;
            default:        nb_sel = ctl.nb_second ? nxt_reg : prev_reg;
        endcase
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:  xval = m_reg;
            CMD_INS_AFTER, CMD_INS_BEFORE:  xval = cur_reg ^ m_reg;
            default:                        xval = nbsec_reg ? (cur_reg ^ prev_reg)
                                                             : (cur_reg ^ nxt_reg);
        endcase
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_PUSH_FRONT: new_link = head_reg;
            CMD_PUSH_BACK:  new_link = tail_reg;
            CMD_INS_AFTER:  new_link = cur_reg ^ nxt_reg;
            default:        new_link = prev_reg ^ cur_reg;
        endcase
        cur_link    = (cmd_reg == CMD_INS_AFTER) ? (prev_reg ^ m_reg) : (m_reg ^ nxt_reg);
        new_key_val = (cmd_reg == CMD_PUSH_FRONT || cmd_reg == CMD_PUSH_BACK)
                      ? key_reg : nkey_reg;
    end

    // one read port and one write port per store
    always_comb
    begin
        rd_en   = (ctl.op == OP_RD_CUR) || (ctl.op == OP_RD_NB);
        rd_idx  = (ctl.op == OP_RD_NB) ? nb_sel : cur_reg;
        kw_en   = (ctl.op == OP_WR_NEW);
        lw_en   = 1'b0;
        lw_idx  = m_reg;
        lw_data = new_link;
        case (ctl.op)
            OP_WR_NEW:
            begin
                lw_en = 1'b1;
            end
            OP_WR_CUR:
            begin
                lw_en   = 1'b1;
                lw_idx  = cur_reg;
                lw_data = cur_link;
            end
            OP_WR_NB:
            begin
                lw_en   = 1'b1;
                lw_idx  = nb_reg;
                lw_data = lq_reg ^ xval;
            end
            default:
            begin
                lw_en = 1'b0;
            end
        endcase
    end

    assign rd_m1     = rd_idx - 1'b1;
    assign lw_m1     = lw_idx - 1'b1;
    assign m_m1      = m_reg - 1'b1;
    assign scan_m1   = scan_reg - 1'b1;
    assign cur_m1    = cur_reg - 1'b1;
    assign scan_free = free_reg[scan_m1[ADDR_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            key_mem[m_m1[ADDR_W-1:0]] <= new_key_val;
        end
        if (lw_en)
        begin
            link_mem[lw_m1[ADDR_W-1:0]] <= lw_data;
        end
        if (rd_en)
        begin
            kq_reg <= key_mem[rd_m1[ADDR_W-1:0]];
            lq_reg <= link_mem[rd_m1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            free_reg  <= '1;
            out_valid <= 1'b0;
        end
        else
        begin
            if (ctl.op == OP_EMIT)
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (ctl.op)
                OP_TAKE:
                begin
                    free_reg[scan_m1[ADDR_W-1:0]] <= 1'b0;
                end
                OP_COMMIT:
                begin
                    case (cmd_reg)
                        CMD_PUSH_FRONT:
                        begin
                            head_reg <= m_reg;
                            if (cnt_reg == '0)
                            begin
                                tail_reg <= m_reg;
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        CMD_PUSH_BACK:
                        begin
                            tail_reg <= m_reg;
                            if (cnt_reg == '0)
                            begin
                                head_reg <= m_reg;
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        CMD_INS_AFTER:
                        begin
                            if (nxt_reg == '0)
                            begin
                                tail_reg <= m_reg;
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        CMD_INS_BEFORE:
                        begin
                            if (prev_reg == '0)
                            begin
                                head_reg <= m_reg;
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE:
                        begin
                            if (prev_reg == '0)
                            begin
                                head_reg <= nxt_reg;
                            end
                            if (nxt_reg == '0)
                            begin
                                tail_reg <= prev_reg;
                            end
                            cnt_reg                     <= cnt_reg - 1'b1;
                            free_reg[cur_m1[ADDR_W-1:0]] <= 1'b1;
                        end
                        CMD_REVERSE:
                        begin
                            head_reg <= tail_reg;
                            tail_reg <= head_reg;
                        end
                        default:
                        begin
                            cnt_reg <= cnt_reg;
                        end
                    endcase
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    assign kout_wide = (KW + KEY_W)'(kout_reg);
    assign idx_wide  = (IDX_W + IDX_PW)'(idx_reg);
    assign cnt_wide  = (IDX_W + IDX_PW)'(cnt_reg);

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                cmd_reg    <= cmd_t'(in_cmd);
                key_reg    <= in_key[KW-1:0];
                nkey_reg   <= in_new_key[KW-1:0];
                status_reg <= ST_OK;
                kout_reg   <= '0;
                idx_reg    <= '0;
            end
            OP_FAIL:
            begin
                status_reg <= ctl.fail_code;
            end
            OP_SEEK_INIT:
            begin
                cur_reg  <= head_reg;
                prev_reg <= '0;
                step_reg <= '0;
            end
            OP_TAIL_INIT:
            begin
                cur_reg  <= tail_reg;
                prev_reg <= '0;
            end
            OP_ADVANCE:
            begin
                prev_reg <= cur_reg;
                cur_reg  <= prev_reg ^ lq_reg;
                step_reg <= step_reg + 1'b1;
            end
            OP_FOUND:
            begin
                khit_reg <= kq_reg;
                if (cmd_reg == CMD_POP_BACK)
                begin
                    prev_reg <= lq_reg;
                    nxt_reg  <= '0;
                end
                else
                begin
                    nxt_reg <= prev_reg ^ lq_reg;
                end
            end
            OP_SCAN_INIT:
            begin
                scan_reg <= IDX_W'(1);
            end
            OP_SCAN_STEP:
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            OP_TAKE:
            begin
                m_reg <= scan_reg;
            end
            OP_RD_NB:
            begin
                nb_reg    <= nb_sel;
                nbsec_reg <= ctl.nb_second;
            end
            OP_COMMIT:
            begin
                case (cmd_reg)
                    CMD_FIND:
                    begin
                        idx_reg <= cur_reg;
                    end
                    CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE:
                    begin
                        idx_reg  <= cur_reg;
                        kout_reg <= khit_reg;
                    end
                    default:
                    begin
                        idx_reg <= idx_reg;
                    end
                endcase
            end
            OP_EMIT:
            begin
                ostat_reg  <= status_reg;
                okey_reg   <= kout_wide[KEY_W-1:0];
                oidx_reg   <= idx_wide[IDX_PW-1:0];
                ocnt_reg   <= cnt_wide[IDX_PW-1:0];
                oempty_reg <= (cnt_reg == '0);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign out_status = ostat_reg;
    assign out_key    = okey_reg;
    assign out_index  = oidx_reg;
    assign out_count  = ocnt_reg;
    assign out_empty  = oempty_reg;

    always_comb
    begin
        sts           = '0;
        sts.cmd       = cmd_reg;
        sts.empty     = (cnt_reg == '0);
        sts.full      = (cnt_reg == CAP_IDX);
        sts.walk_end  = (step_reg == cnt_reg) || (cur_reg == '0);
        sts.key_hit   = (kq_reg == key_reg);
        sts.scan_free = scan_free;
        sts.nb_zero   = (nb_sel == '0);
        sts.out_busy  = out_valid && !out_ready;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_IDX)
        else $error("list length beyond pool size");

    a_head_nil: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == '0) == (cnt_reg == '0))
        else $error("head nil out of step with length");

    a_tail_nil: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg == '0) == (cnt_reg == '0))
        else $error("tail nil out of step with length");

    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_TAKE) |-> scan_free)
        else $error("allocated node not free");

endmodule

### sv/xor_linked_deque_engine_core.sv
// Keyed deque kept as an XOR-linked list in a pool of CAPACITY nodes (1..CAPACITY, 0 is nil),
// one request at a time with one response per request. The path depends on the command:
// reverse and unused codes go from dispatch straight to the response; pops read the end
// node, then unlink each neighbor that exists; push runs the lowest-free-first allocation scan
// over up to CAPACITY pool entries, writes the new node and relinks the old end node if any;
// find, insert and remove walk from the head, each step waiting on the registered read of the
// link store, and inserts add the allocation scan. A new request is taken while the previous
// response still waits in the output register; the next response then holds the block until
// that one is taken.
module xor_linked_deque_engine_core
    import xld_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    xld_req_if.sink    req,
    xld_rsp_if.source  rsp
);

    xld_ctl_t ctl;
    xld_sts_t sts;

    xld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    xld_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (req.cmd),
        .in_key     (req.key),
        .in_new_key (req.new_key),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_key    (rsp.key_out),
        .out_index  (rsp.node_index),
        .out_count  (rsp.count),
        .out_empty  (rsp.empty_res)
    );

endmodule
